FILE: rtl/core/emb3_pkg.sv
`timescale 1ns / 1ps

package emb3_pkg;

	// pixel and channel widths
	localparam int PIX_W = 24;
	localparam int CH_W  = 8;
	localparam int CH_N  = 3;

	// frame dimension registers and position counters
	localparam int DIM_W   = 12;
	localparam int POS_W   = 11;
	localparam int DIM_MIN = 3;
	localparam int DIM_MAX = 2048;

	// signed channel sum: -1020 .. 1275
	localparam int SUM_W = 12;

	// register indexes on the configuration port
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	// item kinds carried on the input tuser
	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	// where the result of an item comes from
	typedef enum logic [2:0] {
		SRC_NONE,
		SRC_TAIL,
		SRC_LINE,
		SRC_CENTER,
		SRC_EMB
	} src_t;

	// control carried from the accept stage to the memory data stage
	typedef struct packed {
		logic              is_pix;
		src_t              src;
		logic              last;
		logic              tail_wr;
		logic [PIX_W-1:0]  pix;
	} s1_ctl_t;

endpackage

FILE: rtl/core/emb3_ram.sv
`timescale 1ns / 1ps

module emb3_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 2048
) (
	input  logic                                    clk,
	input  logic                                    wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                        wr_data,
	input  logic                                    rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                        rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: rtl/core/emboss_3x3_filter_top.sv
`timescale 1ns / 1ps

// 3x3 emboss filter over an RGB pixel stream in raster order.
// Input stream: s_tdata = {blue, green, red} (red in bits 7:0), s_tuser = 0 for a
// pixel, 1 for a flush item. Output stream: m_tdata = {blue, green, red},
// m_tlast marks the final result of a frame.
// Each pixel at row R, column C gives the result for row R-1, column C-1; border
// pixels pass through unchanged. After the last pixel of a frame, send W+1 flush
// items to drain the remaining results; a pixel sent instead starts a new frame.
// Throughput: one item per clock while m_tready stays high. A result shows on
// m_tvalid after the line store read, then kernel sum, then output register.
// The line stores are two single-port-write, registered-read memories read
// once per item, which sets the one-item pace.
// Reset clears positions, window and handshake state; width and height return
// to 640 and 480. The line stores need no clearing pass: a frame fills them
// before it reads them. Writing either register restarts the frame.
// When m_tready is low, the output register holds and up to two more results
// queue inside; s_tready then falls until the output moves.
module emboss_3x3_filter_top #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // red_in, green_in, blue_in
	input  logic        s_tuser,   // op
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // red_out, green_out, blue_out
	output logic        m_tlast    // frame_last
);

	localparam int AW       = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int WMAX_INT = (MAX_WIDTH < emb3_pkg::DIM_MAX) ? MAX_WIDTH : emb3_pkg::DIM_MAX;
	localparam int WRST_INT = (640 < WMAX_INT) ? 640 : WMAX_INT;
	localparam logic [emb3_pkg::DIM_W-1:0] WMAX = emb3_pkg::DIM_W'(WMAX_INT);
	localparam logic [emb3_pkg::DIM_W-1:0] WRST = emb3_pkg::DIM_W'(WRST_INT);
	localparam logic [emb3_pkg::DIM_W-1:0] HRST = emb3_pkg::DIM_W'(480);
	localparam logic [emb3_pkg::DIM_W-1:0] DMIN = emb3_pkg::DIM_W'(emb3_pkg::DIM_MIN);
	localparam logic [emb3_pkg::DIM_W-1:0] HMAX = emb3_pkg::DIM_W'(emb3_pkg::DIM_MAX);

	// configuration and position state
	logic [emb3_pkg::DIM_W-1:0] width_q, height_q;
	logic [emb3_pkg::POS_W-1:0] col_q, row_q;
	logic [emb3_pkg::DIM_W-1:0] pend_q;
	logic                       cfg_wr;
	logic [emb3_pkg::DIM_W-1:0] cfg_val, cfg_w, cfg_h;

	// accept stage
	logic                       accept;
	logic                       is_flush;
	logic [emb3_pkg::PIX_W-1:0] in_pix;
	logic [emb3_pkg::POS_W-1:0] cur_col;
	logic                       col_last, row_last;
	logic                       fl_ok, fl_first;
	logic [emb3_pkg::DIM_W-1:0] fl_addr;
	emb3_pkg::src_t             src0;
	logic [AW-1:0]              old_raddr, new_raddr;

	// memory data stage
	logic                       v1_s1;
	emb3_pkg::s1_ctl_t          ctl_s1;
	logic [AW-1:0]              addr_s1;
	logic [emb3_pkg::PIX_W-1:0] old_rd, new_rd;
	logic                       emit1, adv1, wr_en;
	logic [emb3_pkg::PIX_W-1:0] sel_pix;
	logic signed [emb3_pkg::SUM_W-1:0] sum1 [emb3_pkg::CH_N];
	logic [emb3_pkg::PIX_W-1:0] win_q [3][2];
	logic [emb3_pkg::PIX_W-1:0] tail_q;

	// sum stage and output register
	logic                       v2_s2, emb_s2, last_s2;
	logic signed [emb3_pkg::SUM_W-1:0] sum_s2 [emb3_pkg::CH_N];
	logic [emb3_pkg::PIX_W-1:0] pix_s2;
	logic                       hold, s2_free, out_load;
	logic                       out_valid_q, out_last_q;
	logic [emb3_pkg::PIX_W-1:0] out_pix_q, out_pix_d;

	// configuration port
	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign cfg_val = pwdata[emb3_pkg::DIM_W-1:0];
	assign cfg_w   = (cfg_val < DMIN) ? DMIN : ((cfg_val > WMAX) ? WMAX : cfg_val);
	assign cfg_h   = (cfg_val < DMIN) ? DMIN : ((cfg_val > HMAX) ? HMAX : cfg_val);
	assign prdata  = (paddr[2] == emb3_pkg::REG_HEIGHT) ? {20'd0, height_q} : {20'd0, width_q};

	// accept-stage decode
	assign accept   = s_tvalid & s_tready;
	assign is_flush = (s_tuser == emb3_pkg::OP_FLUSH);
	assign in_pix   = {s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]};
	assign cur_col  = ({1'b0, col_q} >= width_q) ? '0 : col_q;
	assign col_last = ({1'b0, cur_col} + 12'd1) >= width_q;
	assign row_last = ({1'b0, row_q} + 12'd1) >= height_q;
	assign fl_ok    = (pend_q != '0) && ({1'b0, pend_q} <= ({1'b0, width_q} + 13'd1));
	assign fl_first = ({1'b0, pend_q} == ({1'b0, width_q} + 13'd1));
	assign fl_addr  = width_q - pend_q;

	always_comb begin
		src0 = emb3_pkg::SRC_NONE;
		if (is_flush) begin
			if (fl_ok) begin
				src0 = fl_first ? emb3_pkg::SRC_TAIL : emb3_pkg::SRC_LINE;
			end
		end else if (cur_col == '0) begin
			if (row_q >= 11'd2) begin
				src0 = emb3_pkg::SRC_TAIL;
			end
		end else if (row_q >= 11'd1) begin
			if (row_q >= 11'd2 && cur_col >= 11'd2) begin
				src0 = emb3_pkg::SRC_EMB;
			end else begin
				src0 = emb3_pkg::SRC_CENTER;
			end
		end
	end

	assign old_raddr = AW'(cur_col);
	assign new_raddr = is_flush ? AW'(fl_addr) : AW'(cur_col);

	// configuration, positions and pending flush count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WRST;
			height_q <= HRST;
			col_q    <= '0;
			row_q    <= '0;
			pend_q   <= '0;
		end else if (cfg_wr) begin
			if (paddr[2] == emb3_pkg::REG_WIDTH) begin
				width_q <= cfg_w;
			end else begin
				height_q <= cfg_h;
			end
			col_q  <= '0;
			row_q  <= '0;
			pend_q <= '0;
		end else if (accept) begin
			if (is_flush) begin
				if (fl_ok) begin
					pend_q <= pend_q - 12'd1;
				end
			end else begin
				pend_q <= '0;
				if (col_last) begin
					col_q <= '0;
					if (row_last) begin
						row_q  <= '0;
						pend_q <= width_q + 12'd1;
					end else begin
						row_q <= row_q + 11'd1;
					end
				end else begin
					col_q <= cur_col + 11'd1;
				end
			end
		end
	end

	// line stores
	emb3_ram #(.WIDTH(emb3_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_older (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (addr_s1),
		.wr_data (new_rd),
		.rd_en   (accept),
		.rd_addr (old_raddr),
		.rd_data (old_rd)
	);

	emb3_ram #(.WIDTH(emb3_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_newer (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (addr_s1),
		.wr_data (ctl_s1.pix),
		.rd_en   (accept),
		.rd_addr (new_raddr),
		.rd_data (new_rd)
	);

	// pipeline flow control
	assign hold     = out_valid_q & ~m_tready;
	assign s2_free  = ~v2_s2 | ~hold;
	assign out_load = v2_s2 & ~hold;
	assign emit1    = (ctl_s1.src != emb3_pkg::SRC_NONE);
	assign adv1     = v1_s1 & (~emit1 | s2_free);
	assign s_tready = ~v1_s1 | adv1;
	assign wr_en    = adv1 & ctl_s1.is_pix;

	// advance the accept stage into s1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
		end else if (accept) begin
			v1_s1 <= 1'b1;
		end else if (adv1) begin
			v1_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s1.is_pix  <= ~is_flush;
			ctl_s1.src     <= src0;
			ctl_s1.last    <= is_flush & (pend_q == 12'd1);
			ctl_s1.tail_wr <= ~is_flush & col_last;
			ctl_s1.pix     <= in_pix;
			addr_s1        <= old_raddr;
		end
	end

	// pick the pass-through value and sum the kernel on the shifted window
	always_comb begin
		case (ctl_s1.src)
			emb3_pkg::SRC_TAIL:   sel_pix = tail_q;
			emb3_pkg::SRC_LINE:   sel_pix = new_rd;
			emb3_pkg::SRC_CENTER: sel_pix = win_q[1][1];
			default:              sel_pix = '0;
		endcase
		for (int ch = 0; ch < emb3_pkg::CH_N; ch++) begin
			sum1[ch] = - ($signed({4'd0, win_q[0][0][ch*8 +: 8]}) <<< 1)
				- $signed({4'd0, win_q[0][1][ch*8 +: 8]})
				- $signed({4'd0, win_q[1][0][ch*8 +: 8]})
				+ $signed({4'd0, win_q[1][1][ch*8 +: 8]})
				+ $signed({4'd0, new_rd[ch*8 +: 8]})
				+ $signed({4'd0, win_q[2][1][ch*8 +: 8]})
				+ ($signed({4'd0, ctl_s1.pix[ch*8 +: 8]}) <<< 1);
		end
	end

	// shift the window (middle and right columns) and hold the row tail
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				win_q[i][0] <= '0;
				win_q[i][1] <= '0;
			end
		end else if (wr_en) begin
			for (int i = 0; i < 3; i++) begin
				win_q[i][0] <= win_q[i][1];
			end
			win_q[0][1] <= old_rd;
			win_q[1][1] <= new_rd;
			win_q[2][1] <= ctl_s1.pix;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && ctl_s1.tail_wr) begin
			tail_q <= new_rd;
		end
	end

	// sum stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_s2 <= 1'b0;
		end else if (adv1 && emit1) begin
			v2_s2 <= 1'b1;
		end else if (out_load) begin
			v2_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && emit1) begin
			emb_s2  <= (ctl_s1.src == emb3_pkg::SRC_EMB);
			last_s2 <= ctl_s1.last;
			pix_s2  <= sel_pix;
			for (int ch = 0; ch < emb3_pkg::CH_N; ch++) begin
				sum_s2[ch] <= sum1[ch];
			end
		end
	end

	// clamp the sums to a byte, or pass the selected pixel through for border results
	always_comb begin
		for (int ch = 0; ch < emb3_pkg::CH_N; ch++) begin
			if (!emb_s2) begin
				out_pix_d[ch*8 +: 8] = pix_s2[ch*8 +: 8];
			end else if (sum_s2[ch] < 0) begin
				out_pix_d[ch*8 +: 8] = 8'd0;
			end else if (sum_s2[ch] > 12'sd255) begin
				out_pix_d[ch*8 +: 8] = 8'd255;
			end else begin
				out_pix_d[ch*8 +: 8] = sum_s2[ch][7:0];
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_pix_q  <= out_pix_d;
			out_last_q <= last_s2;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_pix_q[7:0], out_pix_q[15:8], out_pix_q[23:16]};
	assign m_tlast  = out_last_q;

endmodule

FILE: tb/sv/emboss_3x3_filter_top_tb.sv
`timescale 1ns / 1ps

module emboss_3x3_filter_top_tb;

	localparam int PIPE_LAT = 3;
	localparam int IDLE_PCT = 12;
	localparam int RANDOM_ITEMS = 400;

	typedef struct packed {
		logic [emb3_pkg::PIX_W-1:0] pix;
		logic                       last;
	} pixel_result_t;

	// Predicts filtered pixels from accepted items and checks them in order
	class emboss_scoreboard;
		bit [emb3_pkg::PIX_W-1:0] older_line [emb3_pkg::DIM_MAX];
		bit [emb3_pkg::PIX_W-1:0] newer_line [emb3_pkg::DIM_MAX];
		bit [emb3_pkg::PIX_W-1:0] window [3][3];
		int                       col;
		int                       row;
		int                       pending;
		int                       width;
		int                       height;
		int                       errors;
		pixel_result_t            expected_pixels [$];

		function new();
			width = 640;
			height = 480;
		endfunction

		function int clamp_dim(int v, int hi);
			if (v < emb3_pkg::DIM_MIN)
				return emb3_pkg::DIM_MIN;
			if (v > hi)
				return hi;
			return v;
		endfunction

		// Register write: clamp and restart the frame
		function void write_register(logic idx, logic [31:0] value);
			if (idx == emb3_pkg::REG_WIDTH)
				width = clamp_dim(int'(value[emb3_pkg::DIM_W-1:0]), emb3_pkg::DIM_MAX);
			else
				height = clamp_dim(int'(value[emb3_pkg::DIM_W-1:0]), emb3_pkg::DIM_MAX);
			col = 0;
			row = 0;
			pending = 0;
		endfunction

		function int tap(int i, int j, int k);
			return int'(window[i][j][emb3_pkg::CH_W*k +: emb3_pkg::CH_W]);
		endfunction

		// Emboss kernel on one channel, clamped to 0..255
		function bit [emb3_pkg::CH_W-1:0] emboss_channel(int k);
			int s;
			s = 2 * (tap(2, 2, k) - tap(0, 0, k)) - tap(0, 1, k) - tap(1, 0, k)
				+ tap(1, 1, k) + tap(1, 2, k) + tap(2, 1, k);
			if (s > 255)
				s = 255;
			if (s < 0)
				s = 0;
			return s[emb3_pkg::CH_W-1:0];
		endfunction

		function void note_item(logic op, logic [emb3_pkg::PIX_W-1:0] pix);
			int                       c;
			int                       r;
			int                       idx;
			bit [emb3_pkg::PIX_W-1:0] tail;
			bit [emb3_pkg::PIX_W-1:0] above2;
			bit [emb3_pkg::PIX_W-1:0] above1;
			bit [emb3_pkg::PIX_W-1:0] res;
			bit                       has_res;

			// Flush: drain one pending result of the finished frame
			if (op == emb3_pkg::OP_FLUSH) begin
				if (pending == 0 || pending > width + 1)
					return;
				idx = width + 1 - pending;
				res = (idx == 0) ? older_line[width-1] : newer_line[idx-1];
				pending--;
				expected_pixels.push_back('{pix: res, last: (pending == 0)});
				return;
			end

			// Pixel: drop anything pending, update line stores and window
			pending = 0;
			c = (col >= width) ? 0 : col;
			r = row;
			tail = older_line[width-1];
			above2 = older_line[c];
			above1 = newer_line[c];
			older_line[c] = above1;
			newer_line[c] = pix;
			for (int i = 0; i < 3; i++) begin
				window[i][0] = window[i][1];
				window[i][1] = window[i][2];
			end
			window[0][2] = above2;
			window[1][2] = above1;
			window[2][2] = pix;

			has_res = 1'b0;
			if (c == 0) begin
				// right border pixel of two rows up passes through
				if (r >= 2) begin
					res = tail;
					has_res = 1'b1;
				end
			end else if (r >= 1) begin
				if (r >= 2 && c >= 2) begin
					for (int k = 0; k < emb3_pkg::CH_N; k++)
						res[emb3_pkg::CH_W*k +: emb3_pkg::CH_W] = emboss_channel(k);
				end else begin
					res = window[1][1];
				end
				has_res = 1'b1;
			end
			if (has_res)
				expected_pixels.push_back('{pix: res, last: 1'b0});

			// Advance position, arm the drain on the last pixel of the frame
			if (c + 1 >= width) begin
				col = 0;
				if (r + 1 >= height) begin
					row = 0;
					pending = width + 1;
				end else begin
					row = r + 1;
				end
			end else begin
				col = c + 1;
				row = r;
			end
		endfunction

		function void check_pixel(logic [emb3_pkg::PIX_W-1:0] data, logic last);
			string         chan_name [emb3_pkg::CH_N] = '{"red_out", "green_out", "blue_out"};
			pixel_result_t exp_px;

			if (expected_pixels.size() == 0) begin
				$error("result with no pending expectation: tdata %h tlast %b", data, last);
				errors++;
				return;
			end
			exp_px = expected_pixels.pop_front();
			for (int k = 0; k < emb3_pkg::CH_N; k++) begin
				if (data[emb3_pkg::CH_W*k +: emb3_pkg::CH_W] !==
					exp_px.pix[emb3_pkg::CH_W*k +: emb3_pkg::CH_W]) begin
					$error("%s: expected %0d, got %0d", chan_name[k],
						exp_px.pix[emb3_pkg::CH_W*k +: emb3_pkg::CH_W],
						data[emb3_pkg::CH_W*k +: emb3_pkg::CH_W]);
					errors++;
				end
			end
			if (last !== exp_px.last) begin
				$error("frame_last: expected %0d, got %0d", exp_px.last, last);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;   // red_in, green_in, blue_in
	logic        s_tuser = 1'b0; // op
	logic        m_tvalid;
	logic        m_tready = 1'b1;
	logic [23:0] m_tdata;        // red_out, green_out, blue_out
	logic        m_tlast;        // frame_last

	bit               steady = 1'b0;
	int               items_sent = 0;
	emboss_scoreboard sb = new();

	emboss_3x3_filter_top u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Randomly stall the output side
	always @(negedge clk) begin
		m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	// Check every output transfer
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_pixel(m_tdata, m_tlast);
	end

	function automatic logic [emb3_pkg::PIX_W-1:0] rand_pixel();
		logic [emb3_pkg::PIX_W-1:0] pix;
		for (int k = 0; k < emb3_pkg::CH_N; k++) begin
			case ($urandom_range(0, 5))
				0: pix[emb3_pkg::CH_W*k +: emb3_pkg::CH_W] = '0;
				1: pix[emb3_pkg::CH_W*k +: emb3_pkg::CH_W] = '1;
				default: pix[emb3_pkg::CH_W*k +: emb3_pkg::CH_W] =
					emb3_pkg::CH_W'($urandom_range(0, 255));
			endcase
		end
		return pix;
	endfunction

	// Drive one item from a falling edge and hold it until the transfer
	task automatic send_item(input logic op, input logic [emb3_pkg::PIX_W-1:0] pix);
		if (!steady && $urandom_range(0, 99) < IDLE_PCT)
			@(negedge clk);
		s_tvalid = 1'b1;
		s_tuser = op;
		s_tdata = pix;
		do @(posedge clk); while (!s_tready);
		sb.note_item(op, pix);
		items_sent++;
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	task automatic send_pixels(input int count);
		for (int i = 0; i < count; i++)
			send_item(emb3_pkg::OP_PIXEL, rand_pixel());
	endtask

	task automatic send_flushes(input int count);
		for (int i = 0; i < count; i++)
			send_item(emb3_pkg::OP_FLUSH, rand_pixel());
	endtask

	// Wait for all expected results, then let the pipeline empty
	task automatic settle();
		while (sb.expected_pixels.size() != 0)
			@(negedge clk);
		repeat (PIPE_LAT + 4) @(negedge clk);
	endtask

	// Configuration write: setup then access phase
	task automatic write_register(input logic idx, input logic [emb3_pkg::DIM_W-1:0] value);
		logic [31:0] word;
		word = $urandom();
		word[emb3_pkg::DIM_W-1:0] = value;
		psel = 1'b1;
		pwrite = 1'b1;
		penable = 1'b0;
		paddr = {idx, 2'b00};
		pwdata = word;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		sb.write_register(idx, word);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	// Configuration read: setup then access phase, compare the returned value
	task automatic read_register(input logic idx, input logic [emb3_pkg::DIM_W-1:0] expected);
		string reg_name;
		reg_name = (idx == emb3_pkg::REG_WIDTH) ? "image_width" : "image_height";
		psel = 1'b1;
		pwrite = 1'b0;
		penable = 1'b0;
		paddr = {idx, 2'b00};
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== {20'd0, expected}) begin
			$error("%s: expected %0d, got %0d", reg_name, expected, prdata);
			sb.errors++;
		end
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	function automatic logic [emb3_pkg::DIM_W-1:0] rand_dim(input int hi);
		case ($urandom_range(0, 9))
			0: return emb3_pkg::DIM_W'($urandom_range(0, emb3_pkg::DIM_MIN - 1));
			1: return emb3_pkg::DIM_W'(emb3_pkg::DIM_MIN);
			default: return emb3_pkg::DIM_W'($urandom_range(emb3_pkg::DIM_MIN + 1, hi));
		endcase
	endfunction

	initial begin
		int                         base;
		int                         w;
		int                         h;
		int                         frame_px;
		int                         sent_px;
		logic [emb3_pkg::CH_W-1:0]  hi_ch;
		logic [emb3_pkg::PIX_W-1:0] pix;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset geometry
		read_register(emb3_pkg::REG_WIDTH, emb3_pkg::DIM_W'(640));
		read_register(emb3_pkg::REG_HEIGHT, emb3_pkg::DIM_W'(480));

		// Smallest frame with clamped registers; red sums past 255, blue below 0
		write_register(emb3_pkg::REG_WIDTH, '0);
		write_register(emb3_pkg::REG_HEIGHT, emb3_pkg::DIM_W'(1));
		read_register(emb3_pkg::REG_WIDTH, emb3_pkg::DIM_W'(emb3_pkg::DIM_MIN));
		read_register(emb3_pkg::REG_HEIGHT, emb3_pkg::DIM_W'(emb3_pkg::DIM_MIN));
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				hi_ch = (r >= 1 && c >= 1) ? '1 : '0;
				pix = {~hi_ch, emb3_pkg::CH_W'(100), hi_ch};
				send_item(emb3_pkg::OP_PIXEL, pix);
			end
		end
		// drain, then flush with nothing pending
		send_flushes(4 + 2);
		settle();

		// Partial drain cut short by a new frame, then flush after a register write
		write_register(emb3_pkg::REG_WIDTH, emb3_pkg::DIM_W'(4));
		send_pixels(12);
		send_flushes(2);
		send_pixels(3);
		settle();
		write_register(emb3_pkg::REG_HEIGHT, emb3_pkg::DIM_W'(emb3_pkg::DIM_MIN));
		send_flushes(1);
		settle();

		// Clamp at the top of both ranges
		write_register(emb3_pkg::REG_WIDTH, '1);
		write_register(emb3_pkg::REG_HEIGHT, '1);
		read_register(emb3_pkg::REG_WIDTH, emb3_pkg::DIM_W'(emb3_pkg::DIM_MAX));
		read_register(emb3_pkg::REG_HEIGHT, emb3_pkg::DIM_W'(emb3_pkg::DIM_MAX));

		// Full frame with full drain, no idling on either side
		steady = 1'b1;
		write_register(emb3_pkg::REG_WIDTH, emb3_pkg::DIM_W'(40));
		write_register(emb3_pkg::REG_HEIGHT, emb3_pkg::DIM_W'(6));
		send_pixels(40 * 6);
		send_flushes(40 + 1);
		settle();
		steady = 1'b0;

		// Random frames: mostly complete with full drains, some cut or noisy
		base = items_sent;
		write_register(emb3_pkg::REG_HEIGHT, rand_dim(6));
		while (items_sent - base < RANDOM_ITEMS) begin
			if ($urandom_range(0, 3) == 0) begin
				settle();
				if ($urandom_range(0, 2) != 0)
					write_register(emb3_pkg::REG_WIDTH,
						rand_dim(($urandom_range(0, 7) == 0) ? 40 : 12));
				if ($urandom_range(0, 2) != 0)
					write_register(emb3_pkg::REG_HEIGHT, rand_dim(6));
			end
			w = sb.width;
			h = sb.height;
			frame_px = w * h;
			if ($urandom_range(0, 7) == 0)
				frame_px = $urandom_range(1, w * h - 1);
			sent_px = 0;
			while (sent_px < frame_px) begin
				if ($urandom_range(0, 99) < 3)
					send_item(emb3_pkg::OP_FLUSH, rand_pixel());
				send_item(emb3_pkg::OP_PIXEL, rand_pixel());
				sent_px++;
			end
			if (frame_px == w * h) begin
				case ($urandom_range(0, 19))
					0, 1, 2: send_flushes($urandom_range(0, w));
					3, 4, 5: send_flushes(w + 1 + $urandom_range(1, 3));
					default: send_flushes(w + 1);
				endcase
			end
		end

		settle();
		repeat (8) @(negedge clk);
		if (sb.errors == 0 && sb.expected_pixels.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Hard limit on run time
	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
